### hw/rtl/csc_pkg.sv
// Shared types, codes and helpers of the colour space converter.
`default_nettype none
package csc_pkg;

  typedef enum logic [2:0] {
    SP_RGB     = 3'd0,
    SP_RGBA    = 3'd1,
    SP_HSV     = 3'd2,
    SP_YUV     = 3'd3,
    SP_CMY     = 3'd4,
    SP_CMYK    = 3'd5,
    SP_GRAY    = 3'd6,
    SP_UNKNOWN = 3'd7
  } space_t;

  localparam int NUM_W      = 25;
  localparam int DEN_W      = 17;
  localparam int QUO_W      = 8;
  localparam int DIV_STAGES = QUO_W;
  localparam int LANES      = 3;

  typedef struct packed {
    logic        flag;
    logic        bypass;
    logic        src_hsv;
    logic [2:0]  dst;
    logic [31:0] color;
    logic        szero;
    logic [2:0]  sector;
    logic [7:0]  vv;
    logic [23:0] rgb;
    logic [7:0]  mx;
    logic        hzero;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    side_t                 side;
    lane_t [LANES-1:0]     lane;
  } divw_t;

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/csc_front.sv
// Front stages: conversion to RGB and set-up of the divider lanes.
`default_nettype none
module csc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [5:0]    in_user,
  input  wire logic [31:0]   in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output csc_pkg::divw_t     out_d
);

  logic [2:0]  src, dst;
  logic [7:0]  c0, c1, c2, c3;
  logic [9:0]  t3, cs;
  logic [8:0]  k0, k1, k2;
  logic [7:0]  yg;
  logic [10:0] x6;
  logic [2:0]  sec;
  logic [10:0] remw;
  logic [7:0]  rem;
  csc_pkg::side_t s1_nxt;

  logic           s1_v_r;
  csc_pkg::side_t s1_side_r;
  logic [7:0]     s1_ns_r;
  logic [15:0]    s1_sr_r, s1_st_r;
  logic           s1_ready, s2_ready;

  logic           s2_v_r;
  csc_pkg::divw_t s2_r, s2_nxt;

  logic [7:0]  r, g, b, mx, mn, d;
  logic [10:0] num;
  logic [15:0] vns, q16, t16;
  logic [23:0] vq, vt;

  always_comb begin
    src = in_user[2:0];
    dst = in_user[5:3];
    c0 = in_data[7:0];
    c1 = in_data[15:8];
    c2 = in_data[23:16];
    c3 = in_data[31:24];
    t3 = {1'b0, c0, 1'b0} + {2'b0, c0};
    cs = {2'b0, c1} + {2'b0, c2};
    if (t3 < cs) yg = 8'd0;
    else if (t3 - cs > 10'd255) yg = 8'd255;
    else yg = 8'(t3 - cs);
    k0 = {1'b0, c0} + {1'b0, c3};
    k1 = {1'b0, c1} + {1'b0, c3};
    k2 = {1'b0, c2} + {1'b0, c3};
    x6 = {1'b0, c0, 2'b0} + {2'b0, c0, 1'b0};
    if (x6 >= 11'd1530) begin sec = 3'd0; remw = 11'd0; end
    else if (x6 >= 11'd1275) begin sec = 3'd5; remw = x6 - 11'd1275; end
    else if (x6 >= 11'd1020) begin sec = 3'd4; remw = x6 - 11'd1020; end
    else if (x6 >= 11'd765) begin sec = 3'd3; remw = x6 - 11'd765; end
    else if (x6 >= 11'd510) begin sec = 3'd2; remw = x6 - 11'd510; end
    else if (x6 >= 11'd255) begin sec = 3'd1; remw = x6 - 11'd255; end
    else begin sec = 3'd0; remw = x6; end
    rem = remw[7:0];

    s1_nxt = '0;
    s1_nxt.flag = (src == csc_pkg::SP_UNKNOWN) || (dst == csc_pkg::SP_UNKNOWN);
    s1_nxt.bypass = s1_nxt.flag || (src == dst);
    s1_nxt.src_hsv = (src == csc_pkg::SP_HSV);
    s1_nxt.dst = dst;
    s1_nxt.color = in_data;
    s1_nxt.szero = (c1 == 8'd0);
    s1_nxt.sector = sec;
    s1_nxt.vv = c2;
    case (src)
      csc_pkg::SP_YUV:  s1_nxt.rgb = {c1, yg, c2};
      csc_pkg::SP_CMY:  s1_nxt.rgb = {~c2, ~c1, ~c0};
      csc_pkg::SP_CMYK: s1_nxt.rgb = {
          (k2 >= 9'd255) ? 8'd0 : 8'(9'd255 - k2),
          (k1 >= 9'd255) ? 8'd0 : 8'(9'd255 - k1),
          (k0 >= 9'd255) ? 8'd0 : 8'(9'd255 - k0)};
      csc_pkg::SP_GRAY: s1_nxt.rgb = {c0, c0, c0};
      default:          s1_nxt.rgb = in_data[23:0];
    endcase
  end

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_side_r <= s1_nxt;
      s1_ns_r <= 8'd255 - c1;
      s1_sr_r <= 16'(c1) * 16'(rem);
      s1_st_r <= 16'(c1) * 16'(8'd255 - rem);
    end
  end

  always_comb begin
    r = s1_side_r.rgb[7:0];
    g = s1_side_r.rgb[15:8];
    b = s1_side_r.rgb[23:16];
    mx = csc_pkg::max3(r, g, b);
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (r == mx) begin
      if (g >= b) num = 11'(g - b);
      else num = 11'({d, 2'b0}) + 11'({d, 1'b0}) - 11'(b - g);
    end else if (g == mx) begin
      num = 11'({d, 1'b0}) + 11'(b) - 11'(r);
    end else begin
      num = 11'({d, 2'b0}) + 11'(r) - 11'(g);
    end
    vns = 16'(s1_side_r.vv) * 16'(s1_ns_r);
    q16 = 16'd65025 - s1_sr_r;
    t16 = 16'd65025 - s1_st_r;
    vq = 24'(s1_side_r.vv) * 24'(q16);
    vt = 24'(s1_side_r.vv) * 24'(t16);

    s2_nxt = '0;
    s2_nxt.side = s1_side_r;
    s2_nxt.side.mx = mx;
    s2_nxt.side.hzero = (d == 8'd0);
    if (s1_side_r.src_hsv) begin
      s2_nxt.lane[0].rem = csc_pkg::NUM_W'({vns, 1'b0}) + csc_pkg::NUM_W'(255);
      s2_nxt.lane[0].den = csc_pkg::DEN_W'(510);
      s2_nxt.lane[1].rem = csc_pkg::NUM_W'({vq, 1'b0}) + csc_pkg::NUM_W'(65025);
      s2_nxt.lane[1].den = csc_pkg::DEN_W'(130050);
      s2_nxt.lane[2].rem = csc_pkg::NUM_W'({vt, 1'b0}) + csc_pkg::NUM_W'(65025);
      s2_nxt.lane[2].den = csc_pkg::DEN_W'(130050);
    end else begin
      s2_nxt.lane[0].rem = csc_pkg::NUM_W'({d, 9'b0}) - csc_pkg::NUM_W'({d, 1'b0})
                           + csc_pkg::NUM_W'(mx);
      s2_nxt.lane[0].den = csc_pkg::DEN_W'({mx, 1'b0});
      s2_nxt.lane[1].rem = csc_pkg::NUM_W'({num, 9'b0}) - csc_pkg::NUM_W'({num, 1'b0})
                           + csc_pkg::NUM_W'({d, 2'b0}) + csc_pkg::NUM_W'({d, 1'b0});
      s2_nxt.lane[1].den = csc_pkg::DEN_W'({d, 3'b0}) + csc_pkg::DEN_W'({d, 2'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_d = s2_r;

endmodule
`default_nettype wire

### hw/rtl/csc_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
`default_nettype none
module csc_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  csc_pkg::divw_t     in_d,
  output logic               out_valid,
  input  wire logic          out_ready,
  output csc_pkg::divw_t     out_d
);

  localparam int N = csc_pkg::DIV_STAGES;

  logic           v_r [N];
  csc_pkg::divw_t st_r [N];
  csc_pkg::divw_t stg_in [N];
  csc_pkg::divw_t stg_nxt [N];
  logic           vin [N];
  logic           rdy [N];

  always_comb begin
    logic [csc_pkg::NUM_W-1:0] sh;
    for (int k = 0; k < N; k++) begin
      stg_in[k] = (k == 0) ? in_d : st_r[(k == 0) ? 0 : k - 1];
      vin[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      stg_nxt[k] = stg_in[k];
      for (int l = 0; l < csc_pkg::LANES; l++) begin
        sh = csc_pkg::NUM_W'(stg_in[k].lane[l].den) << (N - 1 - k);
        if (stg_in[k].lane[l].rem >= sh) begin
          stg_nxt[k].lane[l].rem = stg_in[k].lane[l].rem - sh;
          stg_nxt[k].lane[l].quo[N - 1 - k] = 1'b1;
        end
      end
    end
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || ((k == N - 1) ? out_ready : rdy[(k == N - 1) ? k : k + 1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin[k];
      end
      if (rdy[k] && vin[k]) begin
        st_r[k] <= stg_nxt[k];
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v_r[N - 1];
  assign out_d = st_r[N - 1];

endmodule
`default_nettype wire

### hw/rtl/csc_back.sv
// Back stages: HSV sector assembly, conversion from RGB and the output register.
`default_nettype none
module csc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  csc_pkg::divw_t     in_d,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_color,
  output logic               out_flag
);

  logic [7:0]  q0, q1, q2, v;
  logic [23:0] rgbf_nxt, hsv_nxt;

  logic           f1_v_r, f1_ready, f2_ready;
  csc_pkg::side_t f1_side_r;
  logic [23:0]    f1_rgb_r, f1_hsv_r;

  logic        f2_v_r;
  logic [31:0] f2_color_r, color_nxt;
  logic        f2_flag_r;
  logic [7:0]  r, g, b, mx;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg;

  always_comb begin
    q0 = in_d.lane[0].quo;
    q1 = in_d.lane[1].quo;
    q2 = in_d.lane[2].quo;
    v = in_d.side.vv;
    if (!in_d.side.src_hsv) begin
      rgbf_nxt = in_d.side.rgb;
    end else if (in_d.side.szero) begin
      rgbf_nxt = {v, v, v};
    end else begin
      case (in_d.side.sector)
        3'd0:    rgbf_nxt = {q0, q2, v};
        3'd1:    rgbf_nxt = {q0, v, q1};
        3'd2:    rgbf_nxt = {q2, v, q0};
        3'd3:    rgbf_nxt = {v, q1, q0};
        3'd4:    rgbf_nxt = {v, q0, q2};
        default: rgbf_nxt = {q1, q0, v};
      endcase
    end
    if (in_d.side.hzero) hsv_nxt = {in_d.side.mx, 16'd0};
    else hsv_nxt = {in_d.side.mx, q0, q1};
  end

  assign f2_ready = !f2_v_r || out_ready;
  assign f1_ready = !f1_v_r || f2_ready;
  assign in_ready = f1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_ready) begin
      f1_v_r <= in_valid;
    end
    if (f1_ready && in_valid) begin
      f1_side_r <= in_d.side;
      f1_rgb_r <= rgbf_nxt;
      f1_hsv_r <= hsv_nxt;
    end
  end

  always_comb begin
    r = f1_rgb_r[7:0];
    g = f1_rgb_r[15:8];
    b = f1_rgb_r[23:16];
    mx = csc_pkg::max3(r, g, b);
    sum = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'd683;
    avg = prod[18:11];
    if (f1_side_r.bypass) begin
      color_nxt = f1_side_r.color;
    end else begin
      case (f1_side_r.dst)
        csc_pkg::SP_RGBA: color_nxt = {8'hFF, f1_rgb_r};
        csc_pkg::SP_HSV:  color_nxt = {8'h00, f1_hsv_r};
        csc_pkg::SP_YUV:  color_nxt = {8'h00, r, b, avg};
        csc_pkg::SP_CMY:  color_nxt = {8'h00, ~b, ~g, ~r};
        csc_pkg::SP_CMYK: color_nxt = {~mx, mx - b, mx - g, mx - r};
        csc_pkg::SP_GRAY: color_nxt = {24'd0, avg};
        default:          color_nxt = {8'h00, f1_rgb_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_ready) begin
      f2_v_r <= f1_v_r;
    end
    if (f2_ready && f1_v_r) begin
      f2_color_r <= color_nxt;
      f2_flag_r <= f1_side_r.flag;
    end
  end

  assign out_valid = f2_v_r;
  assign out_color = f2_color_r;
  assign out_flag = f2_flag_r;

endmodule
`default_nettype wire

### hw/rtl/color_space_converter.sv
// Top level of the colour space converter.
// Channel | Dir | tdata           | tuser
// in_     | in  | [31:0] color_in | [2:0] src_space, [5:3] func
// out_    | out | [31:0] color_out| [0] passed_through
// One beat is accepted per cycle unless the output stalls a full pipeline; there are
// two front stages, eight divider stages of one quotient bit each, two back stages.
// Reset is synchronous and active low and empties every stage.
// Each stage holds its beat while the next one is full and stalled, and takes
// a new beat into any empty slot, so bubbles close up during a stall.
`default_nettype none
module color_space_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // color_in
  input  wire logic [5:0]  in_tuser,   // src_space, func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // color_out
  output logic [0:0]       out_tuser   // passed_through
);

  logic           fd_valid, fd_ready, db_valid, db_ready;
  csc_pkg::divw_t fd_d, db_d;
  logic           flag;

  csc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_user(in_tuser), .in_data(in_tdata),
    .out_valid(fd_valid), .out_ready(fd_ready), .out_d(fd_d)
  );

  csc_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fd_valid), .in_ready(fd_ready), .in_d(fd_d),
    .out_valid(db_valid), .out_ready(db_ready), .out_d(db_d)
  );

  csc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(db_valid), .in_ready(db_ready), .in_d(db_d),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_color(out_tdata), .out_flag(flag)
  );

  assign out_tuser = flag;

endmodule
`default_nettype wire

### hw/rtl/csc_checker.sv
// Port-level checks of the colour space converter and their binding.
`default_nettype none
module csc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output beat present after reset.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input refused although the output stage is empty.");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("Input refused although the output is being taken.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output beat changed.");

endmodule

bind color_space_converter csc_checker u_csc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

### tb/tb_color_space_converter.sv
// Testbench for the colour space converter: predicted conversions checked beat by beat.
`timescale 1ns / 1ps
module tb_color_space_converter;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [5:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  logic [32:0] pending_colours[$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;

  color_space_converter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] clamp8(input longint x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic logic [31:0] bytes3(input longint a, input longint b, input longint c);
    logic [7:0] x, y, z;
    x = a[7:0];
    y = b[7:0];
    z = c[7:0];
    return {8'd0, z, y, x};
  endfunction

  function automatic logic [31:0] hsv_to_rgb_word(input logic [31:0] w);
    longint hh, ss, vv, sec, rm, p, q, t;
    hh = longint'(w[7:0]);
    ss = longint'(w[15:8]);
    vv = longint'(w[23:16]);
    if (ss == 0) return bytes3(vv, vv, vv);
    sec = (6 * hh) / 255;
    rm = (6 * hh) % 255;
    if (sec >= 6) begin
      sec = 0;
      rm = 0;
    end
    p = (2 * vv * (255 - ss) + 255) / 510;
    q = (2 * vv * (65025 - ss * rm) + 65025) / 130050;
    t = (2 * vv * (65025 - ss * (255 - rm)) + 65025) / 130050;
    case (sec)
      0: return bytes3(vv, t, p);
      1: return bytes3(q, vv, p);
      2: return bytes3(p, vv, t);
      3: return bytes3(p, q, vv);
      4: return bytes3(t, p, vv);
      default: return bytes3(vv, p, q);
    endcase
  endfunction

  function automatic logic [31:0] rgb_to_hsv_word(input longint r, input longint g,
                                                  input longint b);
    longint mx, mn, d, hue, sv, num;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0;
    sv = 0;
    if (mx != 0 && d != 0) begin
      sv = (510 * d + mx) / (2 * mx);
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      if (num < 0) num += 6 * d;
      hue = (510 * num + 6 * d) / (12 * d);
    end
    return bytes3(hue, sv, mx);
  endfunction

  function automatic logic [31:0] into_rgb(input csc_pkg::space_t sp, input logic [31:0] w);
    longint c0, c1, c2, c3;
    c0 = longint'(w[7:0]);
    c1 = longint'(w[15:8]);
    c2 = longint'(w[23:16]);
    c3 = longint'(w[31:24]);
    case (sp)
      csc_pkg::SP_RGB:  return w;
      csc_pkg::SP_RGBA: return bytes3(c0, c1, c2);
      csc_pkg::SP_HSV:  return hsv_to_rgb_word(w);
      csc_pkg::SP_YUV:  return bytes3(c2, longint'(clamp8(3 * c0 - c2 - c1)), c1);
      csc_pkg::SP_CMY:  return bytes3(255 - c0, 255 - c1, 255 - c2);
      csc_pkg::SP_CMYK: return bytes3(longint'(clamp8(255 - c0 - c3)),
                                      longint'(clamp8(255 - c1 - c3)),
                                      longint'(clamp8(255 - c2 - c3)));
      default: return bytes3(c0, c0, c0);
    endcase
  endfunction

  function automatic logic [31:0] out_of_rgb(input csc_pkg::space_t sp, input logic [31:0] w);
    longint r, g, b, mx;
    r = longint'(w[7:0]);
    g = longint'(w[15:8]);
    b = longint'(w[23:16]);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    case (sp)
      csc_pkg::SP_RGB:  return w;
      csc_pkg::SP_RGBA: return w | 32'hFF00_0000;
      csc_pkg::SP_HSV:  return rgb_to_hsv_word(r, g, b);
      csc_pkg::SP_YUV:  return bytes3((r + g + b) / 3, b, r);
      csc_pkg::SP_CMY:  return bytes3(255 - r, 255 - g, 255 - b);
      csc_pkg::SP_CMYK: return bytes3(mx - r, mx - g, mx - b) | 32'((255 - mx) << 24);
      default: return 32'((r + g + b) / 3);
    endcase
  endfunction

  function automatic logic [32:0] predict_colour(input csc_pkg::space_t src,
                                                 input csc_pkg::space_t dst,
                                                 input logic [31:0] w);
    if (src == csc_pkg::SP_UNKNOWN || dst == csc_pkg::SP_UNKNOWN) return {1'b1, w};
    if (src == dst) return {1'b0, w};
    return {1'b0, out_of_rgb(dst, into_rgb(src, w))};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic send_colour(input csc_pkg::space_t src, input csc_pkg::space_t dst,
                             input logic [31:0] w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pending_colours.push_back(predict_colour(src, dst, w));
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= {dst, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic [32:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colours.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 32'd0);
      end else begin
        want = pending_colours.pop_front();
        if (out_tdata !== want[31:0]) report_mismatch("color_out", out_tdata, want[31:0]);
        if (out_tuser[0] !== want[32])
          report_mismatch("passed_through", {31'd0, out_tuser}, {31'd0, want[32]});
      end
    end
  end

  initial begin
    wait (cycle_count >= 2000000);
    $display("tb_color_space_converter: done, errors");
    $finish;
  end

  task automatic test_every_pair();
    int s, d;
    for (s = 0; s < 8; s++)
      for (d = 0; d < 8; d++)
        send_colour(csc_pkg::space_t'(s), csc_pkg::space_t'(d), $urandom());
  endtask

  task automatic test_edge_words();
    logic [31:0] words[8] = '{32'h0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
                              32'h0000_00FF, 32'h00FF_0000, 32'h0000_FF00, 32'h0080_8080};
    int i;
    for (i = 0; i < 8; i++) begin
      send_colour(csc_pkg::SP_RGB, csc_pkg::SP_HSV, words[i]);
      send_colour(csc_pkg::SP_HSV, csc_pkg::SP_RGB, words[i]);
      send_colour(csc_pkg::SP_CMYK, csc_pkg::SP_RGB, words[i]);
    end
    send_colour(csc_pkg::SP_YUV, csc_pkg::SP_RGB, 32'h0000_00FF);
    send_colour(csc_pkg::SP_YUV, csc_pkg::SP_RGB, 32'h00FF_FF00);
  endtask

  task automatic test_random(input int count);
    int i;
    logic [31:0] w;
    for (i = 0; i < count; i++) begin
      w = $urandom();
      if ($urandom_range(3) == 0) w = w & {4{$urandom_range(1) ? 8'hFF : 8'h0F}};
      send_colour(csc_pkg::space_t'($urandom_range(7)), csc_pkg::space_t'($urandom_range(7)),
                  w);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 200;
    test_random(40);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_every_pair();
    test_edge_words();
    test_random(100);
    send_idle_pct = 52;
    test_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random(100);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    test_random(60);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    in_tvalid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) $display("tb_color_space_converter: done, clean");
    else $display("tb_color_space_converter: done, errors");
    $finish;
  end

endmodule
